### src/frame_rate_moving_average_macros.svh
// assertion macros used by the checker file
`ifndef FRAME_RATE_MOVING_AVERAGE_MACROS_SVH
`define FRAME_RATE_MOVING_AVERAGE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FRMA_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("frma assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define FRMA_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("frma assertion failed");

`endif

### src/frma_pkg.sv
package frma_pkg;

    localparam int TS_W          = 32;
    localparam int TPS_W         = 27;
    localparam int RATE_W        = 24;
    localparam int FILL_OUT_W    = 7;
    localparam int FRAC_W        = 8;
    localparam int DIVISOR_W     = 32;

    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 27;

    localparam int WINDOW_DEFAULT = 100;

    localparam logic [TPS_W-1:0]  TPS_RESET          = TPS_W'(1000000);
    localparam logic [RATE_W-1:0] DEFAULT_RATE_RESET = RATE_W'(30720);
    localparam logic [RATE_W-1:0] RATE_MAX           = {RATE_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_SECOND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_RATE     = 1'd1;

    typedef logic [TS_W-1:0]       timestamp_t;
    typedef logic [RATE_W-1:0]     rate_t;
    typedef logic [FILL_OUT_W-1:0] fill_out_t;

endpackage

### src/frma_channels.sv
interface frma_frame_if;
    import frma_pkg::*;

    logic       valid;
    logic       ready;
    timestamp_t timestamp;

    modport source (output valid, output timestamp, input ready);
    modport sink   (input valid, input timestamp, output ready);
endinterface

interface frma_result_if;
    import frma_pkg::*;

    logic      valid;
    logic      ready;
    rate_t     average_rate;
    fill_out_t window_fill;

    modport source (output valid, output average_rate, output window_fill, input ready);
    modport sink   (input valid, input average_rate, input window_fill, output ready);
endinterface

### src/frma_divider.sv
module frma_divider #(
    parameter int DIVIDEND_W = 35,
    parameter int DIVISOR_W  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);
    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // one restoring step per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, div_reg};
        fits    = !diff[DIVISOR_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            count_reg <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            busy_reg  <= (count_reg != CNT_W'(1));
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            div_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

### src/frame_rate_moving_average.sv
// Moving average of the frame rate. Each accepted word on frame is a 32-bit
// tick timestamp; the block forms the modular interval to the previous one,
// turns it into a rate of ticks_per_second * 256 / interval (8 fraction bits,
// saturated to 24 bits, default_rate for a zero interval), keeps the last
// WINDOW rates in a ring memory with a running sum, and returns one word on
// result per frame: the mean over the filled entries and their count. One
// frame is handled at a time; the shared one-bit-per-cycle divider computes
// first the rate, skipped for a zero interval, and then the mean. The next
// frame can be taken as soon as the result is registered, and a finished
// result waits in an output register while that frame is taken in. The user
// must make configuration writes through cfg_we, cfg_index and cfg_data only
// while the block is idle; the block itself does not enforce this.
module frame_rate_moving_average #(
    parameter int WINDOW = frma_pkg::WINDOW_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    frma_frame_if.sink                        frame,
    frma_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [frma_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [frma_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import frma_pkg::*;

    localparam int IDX_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W     = $clog2(WINDOW + 1);
    localparam int SUM_W      = RATE_W + FILL_W;
    localparam int DIVIDEND_W = (TPS_W + FRAC_W > SUM_W) ? TPS_W + FRAC_W : SUM_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RATE   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;
    localparam logic [1:0] S_MEAN   = 2'd3;

    logic [1:0]        state_reg, state_next;
    timestamp_t        prev_time_reg, prev_time_next;
    logic [IDX_W-1:0]  write_index_reg, write_index_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    rate_t             rate_reg, rate_next;
    logic [TPS_W-1:0]  tps_reg;
    rate_t             default_rate_reg;
    logic              out_valid_reg, out_valid_next;
    rate_t             out_avg_reg, out_avg_next;
    fill_out_t         out_fill_reg, out_fill_next;
    rate_t             old_rate_reg;

    rate_t             ring_mem [WINDOW];

    timestamp_t              interval;
    logic                    accept;
    logic                    full;
    logic                    mem_we;
    logic                    div_start;
    logic                    div_busy;
    logic [DIVIDEND_W-1:0]   div_dividend;
    logic [DIVISOR_W-1:0]    div_divisor;
    logic [DIVIDEND_W-1:0]   div_quotient;

    assign frame.ready = (state_reg == S_IDLE);
    assign accept      = frame.valid && (state_reg == S_IDLE);
    assign interval    = frame.timestamp - prev_time_reg;
    assign full        = (fill_reg == FILL_W'(WINDOW));

    always_comb
    begin
        state_next       = state_reg;
        prev_time_next   = prev_time_reg;
        write_index_next = write_index_reg;
        fill_next        = fill_reg;
        sum_next         = sum_reg;
        rate_next        = rate_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_avg_next     = out_avg_reg;
        out_fill_next    = out_fill_reg;
        mem_we           = 1'b0;
        div_start        = 1'b0;
        div_dividend     = '0;
        div_divisor      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (frame.valid)
                begin
                    prev_time_next = frame.timestamp;
                    if (interval == '0)
                    begin
                        rate_next  = default_rate_reg;
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = DIVIDEND_W'({tps_reg, {FRAC_W{1'b0}}});
                        div_divisor  = interval;
                        state_next   = S_RATE;
                    end
                end
            end
            S_RATE:
            begin
                if (!div_busy)
                begin
                    rate_next  = (div_quotient > DIVIDEND_W'(RATE_MAX)) ?
                                 RATE_MAX : div_quotient[RATE_W-1:0];
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                // ring slot was read at accept, so old_rate_reg is the entry leaving
                mem_we    = 1'b1;
                sum_next  = sum_reg - (full ? SUM_W'(old_rate_reg) : SUM_W'(0))
                            + SUM_W'(rate_reg);
                fill_next = full ? fill_reg : fill_reg + FILL_W'(1);
                write_index_next = (write_index_reg == IDX_W'(WINDOW - 1)) ?
                                   '0 : write_index_reg + IDX_W'(1);
                div_start    = 1'b1;
                div_dividend = DIVIDEND_W'(sum_next);
                div_divisor  = DIVISOR_W'(fill_next);
                state_next   = S_MEAN;
            end
            S_MEAN:
            begin
                if (!div_busy && (!out_valid_reg || result.ready))
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = div_quotient[RATE_W-1:0];
                    out_fill_next  = FILL_OUT_W'(fill_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            prev_time_reg    <= '0;
            write_index_reg  <= '0;
            fill_reg         <= '0;
            sum_reg          <= '0;
            out_valid_reg    <= 1'b0;
            tps_reg          <= TPS_RESET;
            default_rate_reg <= DEFAULT_RATE_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            prev_time_reg   <= prev_time_next;
            write_index_reg <= write_index_next;
            fill_reg        <= fill_next;
            sum_reg         <= sum_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TICKS_PER_SECOND: tps_reg          <= cfg_data[TPS_W-1:0];
                    REG_DEFAULT_RATE:     default_rate_reg <= cfg_data[RATE_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rate_reg     <= rate_next;
        out_avg_reg  <= out_avg_next;
        out_fill_reg <= out_fill_next;
    end

    // ring memory, one write and one registered read of a written slot
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[write_index_reg] <= rate_reg;
        end
        if (accept && full)
        begin
            old_rate_reg <= ring_mem[write_index_reg];
        end
    end

    frma_divider #(
        .DIVIDEND_W (DIVIDEND_W),
        .DIVISOR_W  (DIVISOR_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    assign result.valid        = out_valid_reg;
    assign result.average_rate = out_avg_reg;
    assign result.window_fill  = out_fill_reg;
endmodule

### src/frma_checker.sv
`include "frame_rate_moving_average_macros.svh"

module frma_checker #(
    parameter int WINDOW = frma_pkg::WINDOW_DEFAULT
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [frma_pkg::RATE_W-1:0]       average_rate,
    input logic [frma_pkg::FILL_OUT_W-1:0]   window_fill
);
    import frma_pkg::*;

    // a stalled result word holds
    `FRMA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(average_rate) && $stable(window_fill))

    // one frame at a time
    `FRMA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // a result never shows up the cycle after its frame
    `FRMA_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready && (!out_valid || out_ready), !out_valid)

    // at least one entry is always averaged
    `FRMA_ASSERT_NOW(a_fill_nonzero, out_valid, window_fill != '0 || WINDOW >= 128)
endmodule

bind frame_rate_moving_average frma_checker #(
    .WINDOW (WINDOW)
) u_frma_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (frame.valid),
    .in_ready     (frame.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .average_rate (result.average_rate),
    .window_fill  (result.window_fill)
);

### bench/frma_rate_checker.sv
`timescale 1ns / 100ps

module frma_rate_checker #(
    parameter int WINDOW = frma_pkg::WINDOW_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    frma_frame_if                             frame,
    frma_result_if                            result,
    input  logic                              cfg_we,
    input  logic [frma_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [frma_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                pending,
    output int                                failures
);
    import frma_pkg::*;

    typedef struct packed {
        rate_t     average_rate;
        fill_out_t window_fill;
    } mean_word_t;

    mean_word_t        expected_means[$];
    logic [TPS_W-1:0]  ticks_per_second;
    rate_t             zero_interval_rate;
    timestamp_t        last_stamp;
    rate_t             rate_history[WINDOW];
    int unsigned       next_slot;
    int unsigned       filled;
    longint unsigned   rate_sum;
    int                mismatch_count;

    function automatic rate_t rate_for(timestamp_t interval);
        logic [TPS_W+FRAC_W-1:0] numerator;
        logic [TPS_W+FRAC_W-1:0] quotient;
        if (interval == '0)
            return zero_interval_rate;
        numerator = {ticks_per_second, {FRAC_W{1'b0}}};
        quotient = numerator / interval;
        if (quotient > RATE_MAX)
            return RATE_MAX;
        return quotient[RATE_W-1:0];
    endfunction

    function automatic mean_word_t predict_mean(timestamp_t stamp);
        mean_word_t word;
        rate_t      rate;
        rate = rate_for(stamp - last_stamp);
        if (filled >= WINDOW)
            rate_sum -= rate_history[next_slot];
        else
            filled++;
        rate_history[next_slot] = rate;
        rate_sum += rate;
        next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
        last_stamp = stamp;
        word.average_rate = rate_t'(rate_sum / filled);
        word.window_fill = fill_out_t'(filled);
        return word;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mean_word_t want;
        if (!rst_n)
        begin
            expected_means.delete();
            ticks_per_second = TPS_RESET;
            zero_interval_rate = DEFAULT_RATE_RESET;
            last_stamp = '0;
            next_slot = 0;
            filled = 0;
            rate_sum = 0;
            mismatch_count = 0;
            pending <= 0;
            failures <= 0;
        end
        else
        begin
            // result first so a word can never match an expectation made at the same edge
            if (result.valid && result.ready)
            begin
                if (expected_means.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: rate %0d fill %0d",
                             $time, result.average_rate, result.window_fill);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (result.average_rate !== want.average_rate)
                    begin
                        $display("%0t: average_rate expected %0d actual %0d",
                                 $time, want.average_rate, result.average_rate);
                        mismatch_count++;
                    end
                    if (result.window_fill !== want.window_fill)
                    begin
                        $display("%0t: window_fill expected %0d actual %0d",
                                 $time, want.window_fill, result.window_fill);
                        mismatch_count++;
                    end
                end
            end
            if (frame.valid && frame.ready)
                expected_means.push_back(predict_mean(frame.timestamp));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TICKS_PER_SECOND: ticks_per_second = cfg_data[TPS_W-1:0];
                    REG_DEFAULT_RATE:     zero_interval_rate = cfg_data[RATE_W-1:0];
                    default:              ;
                endcase
            end
            pending <= expected_means.size();
            failures <= mismatch_count;
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import frma_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 600;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 192;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     pending;
    int                     failures;
    int                     quiet_cycles;
    bit                     steady;
    bit                     hold_req;
    timestamp_t             last_sent;
    logic [TPS_W-1:0]       cur_tps;

    frma_frame_if  frame_ch();
    frma_result_if result_ch();

    frame_rate_moving_average dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frma_rate_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .failures  (failures)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side
    initial
    begin
        result_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                result_ch.ready <= steady || ($urandom_range(99) >= 24);
        end
    end

    task automatic send_frame(input timestamp_t stamp);
        while (!steady && $urandom_range(99) < 24)
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid <= 1'b1;
        frame_ch.timestamp <= stamp;
        do
            @(posedge clk);
        while (!frame_ch.ready);
        last_sent = stamp;
    endtask

    task automatic wait_drained();
        frame_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_register(input logic [CFG_INDEX_W-1:0] index,
                                    input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        if (index == REG_TICKS_PER_SECOND)
            cur_tps = data[TPS_W-1:0];
    endtask

    function automatic timestamp_t next_stamp();
        int unsigned pick;
        timestamp_t  nominal;
        pick = $urandom_range(99);
        nominal = cur_tps / $urandom_range(240, 20);
        if (nominal == '0)
            nominal = 1;
        if (pick < 75)
            return last_sent + nominal - nominal / 8 + $urandom_range(nominal / 4);
        else if (pick < 83)
            return last_sent;
        else if (pick < 90)
            return last_sent + $urandom_range(64, 1);
        else if (pick < 95)
            return $urandom();
        return last_sent - $urandom_range(1000, 1);
    endfunction

    initial
    begin
        timestamp_t       directed[$];
        logic [TPS_W-1:0] tps_pick;
        rate_t            rate_pick;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_TICKS_PER_SECOND;
        cfg_data <= '0;
        frame_ch.valid <= 1'b0;
        frame_ch.timestamp <= '0;
        steady = 1'b0;
        hold_req = 1'b0;
        last_sent = '0;
        cur_tps = TPS_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: zero first interval, repeat, saturation, wrap, backward
        directed = '{32'h0, 32'h0, 32'h1, 32'd1001, 32'd17668, 32'hFFFF_FFFF, 32'h5,
                     32'h3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'hAAAA_AAAA + 32'd16667, 32'hAAAA_AAAA + 32'd33334};
        foreach (directed[i])
            send_frame(directed[i]);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    tps_pick = TPS_W'(1);
                    rate_pick = '0;
                end
                1:
                begin
                    tps_pick = TPS_W'(100000000);
                    rate_pick = RATE_MAX;
                end
                2:
                begin
                    tps_pick = {TPS_W{1'b1}};
                    rate_pick = RATE_W'($urandom());
                end
                3:
                begin
                    tps_pick = '0;
                    rate_pick = RATE_W'($urandom());
                end
                default:
                begin
                    tps_pick = TPS_W'($urandom_range(100000000, 1));
                    rate_pick = RATE_W'($urandom());
                end
            endcase
            program_register(REG_TICKS_PER_SECOND, tps_pick);
            // upper data bits are don't-care for the rate register
            program_register(REG_DEFAULT_RATE, {3'($urandom_range(7)), rate_pick});
            cfg_we <= 1'b0;
            steady = (phase == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 && n == 40)
                    hold_req = 1'b1;
                send_frame(next_stamp());
            end
            wait_drained();
        end
        steady = 1'b0;

        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
